// ----- rtl/trld_pkg.sv -----
// shared types and codes of the tile residency directory
package trld_pkg;

    // input transaction codes
    localparam logic [1:0] OP_ACCESS = 2'd0;
    localparam logic [1:0] OP_MARK   = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // owner query answers
    localparam logic [1:0] OWN_UNKNOWN = 2'd0;
    localparam logic [1:0] OWN_WRITE   = 2'd1;
    localparam logic [1:0] OWN_OTHER   = 2'd2;

    // configuration register indexes
    localparam logic CFG_STRIDE = 1'b0;
    localparam logic CFG_SLOTS  = 1'b1;

    // fixed field widths
    localparam int COORD_W    = 10;
    localparam int STRIDE_W   = 11;
    localparam int IDX_W      = 21;
    localparam int SLOT_OUT_W = 6;
    localparam int EVT_W      = 11;
    localparam int SLOTS_CFG_W = 7;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 11'd32;

    // broadcast control for the lru cell row
    typedef struct packed {
        logic clear;    // empty all slots, restore identity order
        logic compare;  // register owner match against the key
        logic step;     // shift in from the neighbor toward the tail and load the tail entry
    } trld_cell_ctl_t;

endpackage

// ----- rtl/trld_tile_mem.sv -----
// per-tile store: known flag and host version, registered read
module trld_tile_mem #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11,
    parameter int WORD_W = 33
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/trld_cell.sv -----
// one lru position: slot id, owner, access bits and cached version
module trld_cell import trld_pkg::*; #(
    parameter int POS    = 0,
    parameter int SLOT_W = 6,
    parameter int KEY_W  = 11,
    parameter int CNT_W  = 7,
    parameter int VER_W  = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  trld_cell_ctl_t    ctl,
    input  logic [KEY_W-1:0]  key,
    input  logic [CNT_W-1:0]  n_used,
    input  logic              seen_in,
    output logic              seen_out,
    // neighbor toward the tail
    input  logic [SLOT_W-1:0] nb_slot,
    input  logic              nb_own_v,
    input  logic [KEY_W-1:0]  nb_owner,
    input  logic [1:0]        nb_acc,
    input  logic [VER_W-1:0]  nb_ver,
    // entry entering at the tail
    input  logic [SLOT_W-1:0] tl_slot,
    input  logic              tl_own_v,
    input  logic [KEY_W-1:0]  tl_owner,
    input  logic [1:0]        tl_acc,
    input  logic [VER_W-1:0]  tl_ver,
    // held entry
    output logic [SLOT_W-1:0] slot,
    output logic              own_v,
    output logic [KEY_W-1:0]  owner,
    output logic [1:0]        acc,
    output logic [VER_W-1:0]  ver,
    output logic              match
);

    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              own_v_reg, own_v_next;
    logic [KEY_W-1:0]  owner_reg, owner_next;
    logic [1:0]        acc_reg, acc_next;
    logic [VER_W-1:0]  ver_reg, ver_next;
    logic              match_reg, match_next;
    logic              at_tail, before_tail, shift, load_tail;

    assign at_tail     = (CNT_W'(POS + 1) == n_used);
    assign before_tail = (CNT_W'(POS + 1) < n_used);
    assign seen_out    = seen_in | match_reg;
    assign shift       = ctl.step & seen_out & before_tail;
    assign load_tail   = ctl.step & at_tail;

    always_comb
    begin
        slot_next  = slot_reg;
        own_v_next = own_v_reg;
        owner_next = owner_reg;
        acc_next   = acc_reg;
        ver_next   = ver_reg;
        match_next = match_reg;
        if (ctl.compare)
        begin
            match_next = own_v_reg & (owner_reg == key);
        end
        if (ctl.clear)
        begin
            slot_next  = SLOT_W'(POS);
            own_v_next = 1'b0;
            acc_next   = 2'b00;
            match_next = 1'b0;
        end
        else if (load_tail)
        begin
            slot_next  = tl_slot;
            own_v_next = tl_own_v;
            owner_next = tl_owner;
            acc_next   = tl_acc;
            ver_next   = tl_ver;
        end
        else if (shift)
        begin
            slot_next  = nb_slot;
            own_v_next = nb_own_v;
            owner_next = nb_owner;
            acc_next   = nb_acc;
            ver_next   = nb_ver;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= SLOT_W'(POS);
            own_v_reg <= 1'b0;
            acc_reg   <= 2'b00;
            match_reg <= 1'b0;
        end
        else
        begin
            slot_reg  <= slot_next;
            own_v_reg <= own_v_next;
            acc_reg   <= acc_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        owner_reg <= owner_next;
        ver_reg   <= ver_next;
    end

    assign slot  = slot_reg;
    assign own_v = own_v_reg;
    assign owner = owner_reg;
    assign acc   = acc_reg;
    assign ver   = ver_reg;
    assign match = match_reg;

endmodule

// ----- rtl/tile_residency_lru_directory.sv -----
// top level of the tile residency directory with lru slot replacement
//
//  channel | direction | handshake         | payload
//  s_      | in        | s_tvalid/s_tready | s_tdata tile request, s_tuser opcode and map
//  m_      | out       | m_tvalid/m_tready | m_tdata slot result, m_tuser status
//  cfg_    | in        | cfg_valid/ready   | cfg_index register, cfg_data value
//
// from acceptance to result a request goes through multiply, table read and owner
// compare, match pickup, then the update of the tile table and the lru cell row
// s_tready is high in the idle state only: no request is taken while one is in flight
// a finished result waits in the output register while the next request is taken
// after reset every entry of the tile table is swept clean, with s_tready low
// a stalled m_ side holds the update cycle of the following request only
module tile_residency_lru_directory import trld_pkg::*; #(
    parameter int TILES_PER_MAP = 1024,
    parameter int SLOTS         = 64,
    parameter int VERSION_BITS  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // tile_col, tile_row, want_read, want_write
    input  logic [2:0]  s_tuser,   // opcode, matrix_select
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // slot_index, transfer_needed, evicted_valid,
                                   // evicted_tile, owner_status
    output logic [0:0]  m_tuser,   // status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    localparam int DEPTH  = 2 * TILES_PER_MAP;
    localparam int KEY_W  = $clog2(DEPTH);
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int MEM_W  = 1 + VERSION_BITS;
    localparam int SLOTS_RESET = (SLOTS < 64) ? SLOTS : 64;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_CALC, ST_LOOK, ST_MATCH, ST_EXEC
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [STRIDE_W-1:0] stride_reg, stride_next;
    logic [CNT_W-1:0]    n_used_reg, n_used_next;
    logic [SLOTS_CFG_W-1:0] slots_raw;
    logic                cfg_fire;

    // request fields
    logic [1:0]          op_reg;
    logic                sel_reg;
    logic [COORD_W-1:0]  col_reg, row_reg;
    logic [1:0]          want_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [KEY_W-1:0]    key_reg;
    logic                skip_reg, range_err_reg;
    logic [KEY_W-1:0]    clr_cnt_reg;

    // hit pickup
    logic                hit_reg, hit_next;
    logic [SLOT_W-1:0]   hit_slot_reg, hit_slot_next;
    logic [1:0]          hit_acc_reg, hit_acc_next;
    logic [VERSION_BITS-1:0] hit_ver_reg, hit_ver_next;

    // output register
    logic                m_tvalid_reg;
    logic                status_reg;
    logic [SLOT_OUT_W-1:0] slot_out_reg;
    logic                xfer_reg, evv_reg;
    logic [EVT_W-1:0]    evt_reg;
    logic [1:0]          own_st_reg;

    // tile table
    logic                mem_we, mem_re;
    logic [KEY_W-1:0]    mem_waddr, mem_raddr;
    logic [MEM_W-1:0]    mem_wdata, mem_rdata;
    logic                t_known;
    logic [VERSION_BITS-1:0] t_ver, cur_ver;

    // cell row
    trld_cell_ctl_t      ctl;
    logic [KEY_W-1:0]    key_next;
    logic                in_range;
    logic [SLOT_W-1:0]   c_slot  [SLOTS];
    logic                c_own_v [SLOTS];
    logic [KEY_W-1:0]    c_owner [SLOTS];
    logic [1:0]          c_acc   [SLOTS];
    logic [VERSION_BITS-1:0] c_ver [SLOTS];
    logic                c_match [SLOTS];
    logic                c_seen  [SLOTS+1];
    logic [SLOT_W-1:0]   tl_slot;
    logic [KEY_W-1:0]    tl_owner;
    logic [1:0]          tl_acc;

    logic                s_fire, out_free, exec_go, is_access;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid & s_tready;
    assign out_free  = ~m_tvalid_reg | m_tready;
    assign exec_go   = (state_reg == ST_EXEC) & out_free;
    assign is_access = (op_reg == OP_ACCESS) & ~skip_reg;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;

    // slot count written as 0 acts as 1, above the slot count as all slots
    assign slots_raw = cfg_data[SLOTS_CFG_W-1:0];
    always_comb
    begin
        stride_next = stride_reg;
        n_used_next = n_used_reg;
        if (cfg_fire)
        begin
            case (cfg_index)
                CFG_STRIDE: stride_next = cfg_data;
                CFG_SLOTS:
                begin
                    if (slots_raw == '0)
                        n_used_next = CNT_W'(1);
                    else if (32'(slots_raw) > 32'(SLOTS))
                        n_used_next = CNT_W'(SLOTS);
                    else
                        n_used_next = CNT_W'(slots_raw);
                end
                default: ;
            endcase
        end
    end

    // range check and tile key of the two maps
    assign in_range = (32'(idx_reg) < 32'(TILES_PER_MAP));
    assign key_next = (sel_reg ? KEY_W'(TILES_PER_MAP) : KEY_W'(0)) + KEY_W'(idx_reg);

    // unknown tiles read as version 0
    assign t_known = mem_rdata[MEM_W-1];
    assign t_ver   = mem_rdata[VERSION_BITS-1:0];
    assign cur_ver = t_known ? t_ver : '0;

    // hit entry: at most one cell matches
    always_comb
    begin
        hit_next      = 1'b0;
        hit_slot_next = '0;
        hit_acc_next  = '0;
        hit_ver_next  = '0;
        for (int p = 0; p < SLOTS; p++)
        begin
            if (c_match[p])
            begin
                hit_next      = 1'b1;
                hit_slot_next = hit_slot_next | c_slot[p];
                hit_acc_next  = hit_acc_next | c_acc[p];
                hit_ver_next  = hit_ver_next | c_ver[p];
            end
        end
    end

    // entry that goes to the most recent position
    assign tl_slot  = hit_reg ? hit_slot_reg : c_slot[0];
    assign tl_owner = key_reg;
    assign tl_acc   = hit_reg ? (hit_acc_reg | want_reg) : want_reg;

    assign ctl.clear   = cfg_fire & (cfg_index == CFG_SLOTS);
    assign ctl.compare = (state_reg == ST_LOOK);
    assign ctl.step    = exec_go & is_access;
    // a miss retires the least recent position, a hit the matching one
    assign c_seen[0]   = ~hit_reg;

    // tile table port use
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = key_reg;
        mem_wdata = {1'b1, cur_ver};
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else if (exec_go & ~skip_reg)
        begin
            case (op_reg)
                OP_ACCESS: mem_we = ~t_known;
                OP_MARK:
                begin
                    mem_we    = t_known & want_reg[1];
                    mem_wdata = {1'b1, t_ver + VERSION_BITS'(1)};
                end
                default: mem_we = 1'b0;
            endcase
        end
    end
    assign mem_re    = (state_reg == ST_LOOK);
    assign mem_raddr = key_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_cnt_reg == KEY_W'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (s_fire) state_next = ST_CALC;
            ST_CALC:  state_next = ST_LOOK;
            ST_LOOK:  state_next = ST_MATCH;
            ST_MATCH: state_next = ST_EXEC;
            ST_EXEC:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            stride_reg   <= STRIDE_RESET;
            n_used_reg   <= CNT_W'(SLOTS_RESET);
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            stride_reg <= stride_next;
            n_used_reg <= n_used_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + KEY_W'(1);
            end
            if (exec_go)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            op_reg   <= s_tuser[1:0];
            sel_reg  <= s_tuser[2];
            col_reg  <= s_tdata[9:0];
            row_reg  <= s_tdata[19:10];
            want_reg <= s_tdata[21:20];
        end
        if (state_reg == ST_CALC)
        begin
            // 10 x 11 bit product plus row
            idx_reg <= IDX_W'(col_reg * stride_reg) + IDX_W'(row_reg);
        end
        if (state_reg == ST_LOOK)
        begin
            key_reg       <= key_next;
            range_err_reg <= ~in_range & (op_reg != OP_UNUSED);
            skip_reg      <= ~in_range | (op_reg == OP_UNUSED);
        end
        if (state_reg == ST_MATCH)
        begin
            hit_reg      <= hit_next;
            hit_slot_reg <= hit_slot_next;
            hit_acc_reg  <= hit_acc_next;
            hit_ver_reg  <= hit_ver_next;
        end
        if (exec_go)
        begin
            status_reg   <= range_err_reg;
            slot_out_reg <= '0;
            xfer_reg     <= 1'b0;
            evv_reg      <= 1'b0;
            evt_reg      <= '0;
            own_st_reg   <= OWN_UNKNOWN;
            if (!skip_reg)
            begin
                case (op_reg)
                    OP_ACCESS:
                    begin
                        slot_out_reg <= SLOT_OUT_W'(tl_slot);
                        if (hit_reg)
                        begin
                            xfer_reg <= (hit_ver_reg != cur_ver);
                        end
                        else
                        begin
                            xfer_reg <= 1'b1;
                            evv_reg  <= c_own_v[0];
                            evt_reg  <= c_own_v[0] ? EVT_W'(c_owner[0]) : '0;
                        end
                    end
                    OP_QUERY:
                    begin
                        if (!t_known)
                            own_st_reg <= OWN_UNKNOWN;
                        else if (hit_reg && hit_acc_reg[1])
                            own_st_reg <= OWN_WRITE;
                        else
                            own_st_reg <= OWN_OTHER;
                    end
                    default: ;
                endcase
            end
        end
    end

    trld_tile_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (KEY_W),
        .WORD_W (MEM_W)
    ) u_tiles (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // position 0 is least recent, position n_used - 1 most recent
    for (genvar p = 0; p < SLOTS; p++)
    begin : g_cell
        localparam int NB = (p + 1 < SLOTS) ? p + 1 : p;
        logic [SLOT_W-1:0]       nb_slot;
        logic                    nb_own_v;
        logic [KEY_W-1:0]        nb_owner;
        logic [1:0]              nb_acc;
        logic [VERSION_BITS-1:0] nb_ver;

        // the last position never shifts, it only loads the tail entry
        assign nb_slot  = c_slot[NB];
        assign nb_own_v = c_own_v[NB];
        assign nb_owner = c_owner[NB];
        assign nb_acc   = c_acc[NB];
        assign nb_ver   = c_ver[NB];

        trld_cell #(
            .POS    (p),
            .SLOT_W (SLOT_W),
            .KEY_W  (KEY_W),
            .CNT_W  (CNT_W),
            .VER_W  (VERSION_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .key      (key_next),
            .n_used   (n_used_reg),
            .seen_in  (c_seen[p]),
            .seen_out (c_seen[p+1]),
            .nb_slot  (nb_slot),
            .nb_own_v (nb_own_v),
            .nb_owner (nb_owner),
            .nb_acc   (nb_acc),
            .nb_ver   (nb_ver),
            .tl_slot  (tl_slot),
            .tl_own_v (1'b1),
            .tl_owner (tl_owner),
            .tl_acc   (tl_acc),
            .tl_ver   (cur_ver),
            .slot     (c_slot[p]),
            .own_v    (c_own_v[p]),
            .owner    (c_owner[p]),
            .acc      (c_acc[p]),
            .ver      (c_ver[p]),
            .match    (c_match[p])
        );
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, own_st_reg, evt_reg, evv_reg, xfer_reg, slot_out_reg};

endmodule

// ----- tb/tile_residency_lru_directory_chk.sv -----
// checker for the tile residency directory: predicts each request and compares results
module tile_residency_lru_directory_chk import trld_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic [0:0]  m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [10:0] cfg_data,
    output int          mismatches,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTILES = 2048;
    localparam int NSLOTS = 64;

    typedef struct packed {
        logic       status;
        logic [5:0] slot;
        logic       xfer;
        logic       ev_valid;
        logic [10:0] ev_tile;
        logic [1:0] owner;
    } dir_result_t;

    dir_result_t want_q[$];

    logic [10:0] stride;
    int          nslots;
    logic        known     [NTILES];
    logic [31:0] host_ver  [NTILES];
    logic        linked    [NTILES];
    logic [5:0]  link_slot [NTILES];
    logic        owned     [NSLOTS];
    logic [10:0] owner_key [NSLOTS];
    logic [1:0]  acc_bits  [NSLOTS];
    logic [31:0] dev_ver   [NSLOTS];
    logic [5:0]  lru       [NSLOTS];

    assign pending = want_q.size();

    task automatic empty_slots();
        for (int i = 0; i < NTILES; i++) linked[i] = 1'b0;
        for (int i = 0; i < NSLOTS; i++)
        begin
            owned[i] = 1'b0;
            acc_bits[i] = 2'd0;
            dev_ver[i] = 32'd0;
            lru[i] = 6'(i);
        end
    endtask

    function automatic void promote(input int pos);
        logic [5:0] s;
        if (pos >= nslots) return;
        s = lru[pos];
        for (int p = pos; p + 1 < nslots; p++) lru[p] = lru[p + 1];
        lru[nslots - 1] = s;
    endfunction

    // expected outcome of one request, updating the directory copy
    function automatic dir_result_t resolve(input logic [1:0] op, input logic sel,
                                            input logic [9:0] col, input logic [9:0] row,
                                            input logic [1:0] acc);
        dir_result_t r;
        int          idx;
        int          key;
        int          slot;
        int          old;
        r = '0;
        if (op == OP_UNUSED) return r;
        idx = int'(col) * int'(stride) + int'(row);
        if (idx >= 1024)
        begin
            r.status = 1'b1;
            return r;
        end
        key = int'(sel) * 1024 + idx;
        if (op == OP_MARK)
        begin
            if (known[key] && acc[1]) host_ver[key] = host_ver[key] + 32'd1;
            return r;
        end
        if (op == OP_QUERY)
        begin
            if (!known[key]) r.owner = OWN_UNKNOWN;
            else if (linked[key] && acc_bits[link_slot[key]][1]) r.owner = OWN_WRITE;
            else r.owner = OWN_OTHER;
            return r;
        end
        if (!known[key])
        begin
            known[key] = 1'b1;
            host_ver[key] = 32'd0;
            linked[key] = 1'b0;
        end
        if (linked[key])
        begin
            slot = int'(link_slot[key]);
            for (int p = 0; p < nslots; p++)
                if (lru[p] == 6'(slot))
                begin
                    promote(p);
                    break;
                end
            acc_bits[slot] |= acc;
            r.slot = 6'(slot);
            if (dev_ver[slot] != host_ver[key])
            begin
                dev_ver[slot] = host_ver[key];
                r.xfer = 1'b1;
            end
            return r;
        end
        slot = int'(lru[0]);
        promote(0);
        if (owned[slot] && owner_key[slot] != 11'(key))
        begin
            old = int'(owner_key[slot]);
            linked[old] = 1'b0;
            r.ev_valid = 1'b1;
            r.ev_tile = 11'(old);
        end
        if (!owned[slot] || owner_key[slot] != 11'(key)) acc_bits[slot] = 2'd0;
        acc_bits[slot] |= acc;
        owned[slot] = 1'b1;
        owner_key[slot] = 11'(key);
        linked[key] = 1'b1;
        link_slot[key] = 6'(slot);
        dev_ver[slot] = host_ver[key];
        r.slot = 6'(slot);
        r.xfer = 1'b1;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        dir_result_t got;
        dir_result_t exp_r;
        if (!rst_n)
        begin
            stride = STRIDE_RESET;
            nslots = NSLOTS;
            for (int i = 0; i < NTILES; i++) known[i] = 1'b0;
            empty_slots();
            want_q.delete();
            mismatches <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_STRIDE) stride = cfg_data;
                else
                begin
                    nslots = int'(cfg_data[6:0]);
                    if (nslots < 1) nslots = 1;
                    if (nslots > NSLOTS) nslots = NSLOTS;
                    empty_slots();
                end
            end
            if (s_tvalid && s_tready)
                want_q.push_back(resolve(s_tuser[1:0], s_tuser[2], s_tdata[9:0],
                                         s_tdata[19:10], s_tdata[21:20]));
            if (m_tvalid && m_tready)
            begin
                got = {m_tuser[0], m_tdata[5:0], m_tdata[6], m_tdata[7],
                       m_tdata[18:8], m_tdata[20:19]};
                if (want_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result transaction %h", got);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    exp_r = want_q.pop_front();
                    if (got !== exp_r)
                    begin
                        if (mismatches < 10)
                        begin
                            $write("mismatch: exp st=%0d slot=%0d xf=%0d ev=%0d evt=%0d own=%0d",
                                exp_r.status, exp_r.slot, exp_r.xfer, exp_r.ev_valid,
                                exp_r.ev_tile, exp_r.owner);
                            $display(", got st=%0d slot=%0d xf=%0d ev=%0d evt=%0d own=%0d",
                                got.status, got.slot, got.xfer, got.ev_valid,
                                got.ev_tile, got.owner);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- tb/tile_residency_lru_directory_tb.sv -----
// stimulus and verdict for the tile residency directory
module tile_residency_lru_directory_tb import trld_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // tile_col, tile_row, want_read, want_write
    logic [2:0]  s_tuser = '0;   // opcode, matrix_select
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // slot_index, transfer_needed, evicted_valid,
                                 // evicted_tile, owner_status
    logic [0:0]  m_tuser;        // status
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [10:0] cfg_data = '0;

    int  mismatches;
    int  pending;
    int  cycles = 0;
    bit  calm = 1'b0;            // no idling on either side while set
    int  cur_stride = 32;

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tile_residency_lru_directory uut (.*);

    tile_residency_lru_directory_chk chk (.*);

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // result side back-pressure, about 22 percent stall
    always @(negedge clk)
        m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 22);

    // one request transaction, called at a falling edge
    task automatic send_req(input logic [1:0] op, input logic sel, input logic [9:0] col,
                            input logic [9:0] row, input logic rd, input logic wr);
        s_tvalid = 1'b1;
        s_tuser = {sel, op};
        s_tdata = {2'b00, wr, rd, row, col};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        s_tvalid = 1'b0;
        if (!calm && $urandom_range(0, 99) < 22)
            repeat ($urandom_range(1, 4)) @(negedge clk);
    endtask

    // register write, only while the directory is idle
    task automatic write_reg(input logic [0:0] idx, input logic [10:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        if (idx == CFG_STRIDE) cur_stride = int'(val);
    endtask

    // hold the sender until every result is back, then let the pipe settle
    task automatic drain();
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    // mostly in-range tiles from a small pool so hits and evictions both happen
    task automatic random_req(input int pool);
        logic [1:0] op;
        int         pick;
        int         col;
        int         row;
        int         max_col;
        pick = $urandom_range(0, 99);
        op = (pick < 60) ? OP_ACCESS : (pick < 80) ? OP_MARK :
             (pick < 95) ? OP_QUERY : OP_UNUSED;
        if ($urandom_range(0, 99) < 8 || cur_stride > 1023)
        begin
            col = $urandom_range(0, 1023);
            row = $urandom_range(0, 1023);
        end
        else
        begin
            max_col = (cur_stride == 0) ? 1023 : 1023 / cur_stride;
            if (max_col > 3) max_col = 3;
            col = $urandom_range(0, max_col);
            row = 1023 - col * cur_stride;
            if (row > pool) row = pool;
            row = $urandom_range(0, row);
        end
        send_req(op, 1'($urandom_range(0, 1)), 10'(col), 10'(row),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int strides [7] = '{32, 1, 1024, 0, 2047, 7, 3};
        int slotset [7] = '{64, 4, 1, 0, 127, 64, 17};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: default stride 32, all 64 slots
        send_req(OP_QUERY, 1'b0, 10'd0, 10'd0, 1'b0, 1'b0);      // query of unknown tile
        send_req(OP_MARK, 1'b0, 10'd0, 10'd0, 1'b0, 1'b1);       // mark of unknown tile
        send_req(OP_ACCESS, 1'b0, 10'd0, 10'd0, 1'b1, 1'b0);     // miss, new tile
        send_req(OP_ACCESS, 1'b0, 10'd0, 10'd0, 1'b1, 1'b0);     // hit, same version
        send_req(OP_MARK, 1'b0, 10'd0, 10'd0, 1'b1, 1'b0);       // mark without write
        send_req(OP_MARK, 1'b0, 10'd0, 10'd0, 1'b0, 1'b1);       // version bump
        send_req(OP_ACCESS, 1'b0, 10'd0, 10'd0, 1'b0, 1'b0);     // hit, stale copy
        send_req(OP_QUERY, 1'b0, 10'd0, 10'd0, 1'b0, 1'b0);      // known, not write-held
        send_req(OP_ACCESS, 1'b1, 10'd31, 10'd31, 1'b1, 1'b1);   // last tile of map T
        send_req(OP_QUERY, 1'b1, 10'd31, 10'd31, 1'b0, 1'b0);    // write-held
        send_req(OP_UNUSED, 1'b1, 10'd1023, 10'd1023, 1'b1, 1'b1); // unused opcode
        send_req(OP_ACCESS, 1'b1, 10'd1023, 10'd1023, 1'b1, 1'b1); // out of range
        send_req(OP_ACCESS, 1'b0, 10'd32, 10'd0, 1'b0, 1'b1);    // index exactly 1024
        send_req(OP_MARK, 1'b1, 10'd0, 10'd1023, 1'b0, 1'b1);    // row extreme, mark
        drain();

        write_reg(CFG_SLOTS, 11'd2);   // two slots: force evictions
        for (int i = 0; i < 5; i++)
            send_req(OP_ACCESS, i[0], 10'd0, 10'(i), 1'b1, i[1]);
        send_req(OP_QUERY, 1'b0, 10'd0, 10'd0, 1'b0, 1'b0);      // known but unlinked
        drain();

        for (int ph = 0; ph < 7; ph++)
        begin
            write_reg(CFG_STRIDE, 11'(strides[ph]));
            write_reg(CFG_SLOTS, 11'(slotset[ph]));
            calm = (ph == 5);
            for (int n = 0; n < 270; n++)
                random_req((ph % 2 == 0) ? 90 : 20);
            calm = 1'b0;
            drain();
        end

        repeat (20) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- tile_residency_lru_directory.f -----
rtl/trld_pkg.sv
rtl/trld_tile_mem.sv
rtl/trld_cell.sv
rtl/tile_residency_lru_directory.sv
tb/tile_residency_lru_directory_chk.sv
tb/tile_residency_lru_directory_tb.sv
